// ===== rtl/vca_pkg.sv =====
// Package of the voice channel allocator: request and result transfer types,
// register indexes, sequencer states and fixed constants.
// No dependencies; every other file of the block imports it.
package vca_pkg;

  localparam int unsigned HINT_W   = 5;
  localparam int unsigned MASK_W   = 4;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned VOL_W    = 8;
  localparam int unsigned RATE_W   = 15;
  localparam int unsigned CLOCK_W  = 22;
  localparam int unsigned OVOL_W   = 7;
  localparam int unsigned PLAY_W   = 16;
  localparam int unsigned SERIAL_W = 32;
  localparam int unsigned CFG_W    = 22;
  localparam int unsigned HW_VOICES = 4;

  localparam logic [VOL_W-1:0]   FULL_MIX      = 8'd128;
  localparam logic [OVOL_W-1:0]  MAX_HW_VOL    = 7'd64;
  localparam logic [CLOCK_W-1:0] MIN_PERIOD    = 22'd124;
  localparam logic [RATE_W-1:0]  RATE_RESET    = 15'd22050;
  localparam logic [CLOCK_W-1:0] CLOCK_RESET   = 22'd3546895;

  typedef struct packed {
    logic signed [HINT_W-1:0] requested_channel;
    logic [MASK_W-1:0]        idle_mask;
    logic                     music_on;
    logic [LEN_W-1:0]         sound_length;
  } req_t;

  typedef struct packed {
    logic                 accepted;
    logic [1:0]           hw_channel;
    logic [OVOL_W-1:0]    out_volume;
    logic [CLOCK_W-1:0]   out_period;
    logic [PLAY_W-1:0]    play_length;
    logic                 was_cut;
  } res_t;

  typedef enum logic [2:0] {
    REG_MASTER_VOL  = 3'd0,
    REG_CHAN_VOL_0  = 3'd1,
    REG_CHAN_VOL_1  = 3'd2,
    REG_CHAN_VOL_2  = 3'd3,
    REG_CHAN_VOL_3  = 3'd4,
    REG_SAMPLE_RATE = 3'd5,
    REG_AUDIO_CLOCK = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_MUL,
    ST_EMIT
  } vca_state_e;

endpackage

// ===== rtl/voice_channel_allocator.sv =====
// Voice channel allocator. An accepted request passes through the bit-serial
// period divider, a state that sees it and the voice scan finish, the volume
// product and the load of the result into the output register; a rejected one
// goes straight to the load, which waits while the output register is full and
// not being emptied. One request at a time: a new one is taken only when idle.
// Reset clears the configuration registers to defaults, start serials to zero.
module voice_channel_allocator #(
  parameter int unsigned CHANNELS    = 4,
  parameter int unsigned STAGE_BYTES = 32768
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [2:0]                   cfg_index_i,
  input  logic [vca_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  vca_pkg::req_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output vca_pkg::res_t                out_data_o
);
  import vca_pkg::*;

  localparam int unsigned VW        = $clog2(CHANNELS);
  // The staging size is capped so that the even length fits the result field.
  localparam int unsigned STAGE_CAP = (STAGE_BYTES > 65535) ? 65535 : STAGE_BYTES;

  // Configuration registers. Writes must only be made while the block is idle;
  // the block does not enforce it, and the datapath reads them directly.
  logic [VOL_W-1:0]   master_q;
  logic [VOL_W-1:0]   chan_vol_q [HW_VOICES];
  logic [RATE_W-1:0]  rate_q;
  logic [CLOCK_W-1:0] clock_q;

  vca_state_e         state_q, state_d;
  logic               in_xfer;
  logic [LEN_W-1:0]   clamped;
  logic               cut;
  logic               reject;
  logic [PLAY_W-1:0]  len_q;
  logic               cut_q;
  logic               rej_q;
  logic [2*VOL_W-1:0] prod_q, prod_d;
  logic               out_valid_q, out_valid_d;
  res_t               out_q, out_d;
  logic               commit;

  logic               unit_start;
  logic               div_busy;
  logic [CLOCK_W-1:0] quotient;
  logic [RATE_W-1:0]  rate_eff;
  logic               scan_busy;
  logic [VW-1:0]      voice;
  logic [1:0]         hw2;
  logic               voice_hw;
  logic [VOL_W-1:0]   cv;
  logic [VOL_W-1:0]   vol_raw;
  logic [OVOL_W-1:0]  vol;
  logic [CLOCK_W-1:0] period;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, index values past the list are dropped.
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= FULL_MIX;
      for (int i = 0; i < HW_VOICES; i++) begin
        chan_vol_q[i] <= FULL_MIX;
      end
      rate_q  <= RATE_RESET;
      clock_q <= CLOCK_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MASTER_VOL:  master_q      <= cfg_data_i[VOL_W-1:0];
        REG_CHAN_VOL_0:  chan_vol_q[0] <= cfg_data_i[VOL_W-1:0];
        REG_CHAN_VOL_1:  chan_vol_q[1] <= cfg_data_i[VOL_W-1:0];
        REG_CHAN_VOL_2:  chan_vol_q[2] <= cfg_data_i[VOL_W-1:0];
        REG_CHAN_VOL_3:  chan_vol_q[3] <= cfg_data_i[VOL_W-1:0];
        REG_SAMPLE_RATE: rate_q        <= cfg_data_i[RATE_W-1:0];
        REG_AUDIO_CLOCK: clock_q       <= cfg_data_i[CLOCK_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request intake. The length is clamped to the staging size and made even;
  // a clamped length below two rejects it without starting the divider or scan.
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  assign cut     = in_data_i.sound_length > LEN_W'(STAGE_CAP);
  assign clamped = cut ? LEN_W'(STAGE_CAP) : in_data_i.sound_length;
  assign reject  = clamped < LEN_W'(2);

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      len_q <= {clamped[PLAY_W-1:1], 1'b0};
      cut_q <= cut;
      rej_q <= reject;
    end
  end

  assign unit_start = in_xfer && !reject;

  // A rate of zero divides as one, so the period is then the clock itself.
  assign rate_eff = (rate_q == '0) ? RATE_W'(1) : rate_q;

  vca_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (unit_start),
    .dividend_i (clock_q),
    .divisor_i  (rate_eff),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  vca_scan #(
    .CHANNELS (CHANNELS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (unit_start),
    .hint_i   (in_data_i.requested_channel),
    .mask_i   (in_data_i.idle_mask),
    .music_i  (in_data_i.music_on),
    .commit_i (commit),
    .busy_o   (scan_busy),
    .voice_o  (voice)
  );

  // ---------------------------------------------------------------------------
  // Volume: channel volume times master volume, scaled down by 256 in total
  // (two divisions by 128 with a factor of 64 between them), capped at 64.
  // Voices without a volume register play at full channel volume.
  // ---------------------------------------------------------------------------
  assign hw2      = 2'(voice);
  assign voice_hw = 32'(voice) < 32'(HW_VOICES);
  assign cv       = voice_hw ? chan_vol_q[hw2] : FULL_MIX;
  assign prod_d   = (state_q == ST_MUL) ? cv * master_q : prod_q;
  assign vol_raw  = prod_q[2*VOL_W-1:VOL_W];
  assign vol      = (vol_raw > VOL_W'(MAX_HW_VOL)) ? MAX_HW_VOL : vol_raw[OVOL_W-1:0];
  assign period   = (quotient < MIN_PERIOD) ? MIN_PERIOD : quotient;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // ---------------------------------------------------------------------------
  // Sequencer. The result is loaded into the output register once that is free
  // or being emptied in the same cycle; only an accepted load commits a serial.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    commit      = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = reject ? ST_EMIT : ST_RUN;
        end
      end
      ST_RUN: begin
        if (!div_busy && !scan_busy) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (rej_q) begin
            out_d = '0;
          end else begin
            out_d.accepted    = 1'b1;
            out_d.hw_channel  = hw2;
            out_d.out_volume  = vol;
            out_d.out_period  = period;
            out_d.play_length = len_q;
            out_d.was_cut     = cut_q;
            commit            = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  // Neither shared unit may still be working when a new request can be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!div_busy && !scan_busy))
    else $error("arithmetic unit busy while the block is ready");

  // A started sound carries a legal period, an even length and a capped volume.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.accepted) |->
      (out_data_o.out_period >= MIN_PERIOD && !out_data_o.play_length[0]
       && out_data_o.out_volume <= MAX_HW_VOL))
    else $error("accepted result out of range");

  // A rejected request yields an all-zero result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.accepted) |-> (out_data_o == '0))
    else $error("rejected result not cleared");

  // The serial store only moves when a result is loaded for transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_o)
    else $error("serial committed without a result");

endmodule

// ===== rtl/vca_div.sv =====
// Iterative restoring divider: one quotient bit per cycle, shared subtractor.
// Computes the sample period as audio clock over sample rate; uses vca_pkg.
module vca_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [vca_pkg::CLOCK_W-1:0]   dividend_i,
  input  logic [vca_pkg::RATE_W-1:0]    divisor_i,
  output logic                          busy_o,
  output logic [vca_pkg::CLOCK_W-1:0]   quotient_o
);
  import vca_pkg::*;

  localparam int unsigned CNT_W = $clog2(CLOCK_W + 1);

  logic                busy_q, busy_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CLOCK_W-1:0]  quo_q, quo_d;
  logic [RATE_W-1:0]   rem_q, rem_d;
  logic [RATE_W-1:0]   div_q, div_d;
  logic [RATE_W:0]     shifted;
  logic [RATE_W+1:0]   diff;

  // The shifted partial remainder is one bit wider than the divisor; the top
  // bit of the difference is the borrow.
  assign shifted = {rem_q, quo_q[CLOCK_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(CLOCK_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (diff[RATE_W+1]) begin
        rem_d = shifted[RATE_W-1:0];
        quo_d = {quo_q[CLOCK_W-2:0], 1'b0};
      end else begin
        rem_d = diff[RATE_W-1:0];
        quo_d = {quo_q[CLOCK_W-2:0], 1'b1};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/vca_scan.sv =====
// Voice selection: start serials, serial counter and a one-voice-per-cycle
// scan with a shared serial comparator. Uses vca_pkg.
module vca_scan #(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [vca_pkg::HINT_W-1:0]  hint_i,
  input  logic [vca_pkg::MASK_W-1:0]         mask_i,
  input  logic                               music_i,
  input  logic                               commit_i,
  output logic                               busy_o,
  output logic [$clog2(CHANNELS)-1:0]        voice_o
);
  import vca_pkg::*;

  localparam int unsigned VW = $clog2(CHANNELS);

  logic [SERIAL_W-1:0] serial_q [CHANNELS];
  logic [SERIAL_W-1:0] counter_q, counter_d;
  logic                busy_q, busy_d;
  logic [VW-1:0]       cursor_q, cursor_d;
  logic [VW-1:0]       last_q, last_d;
  logic [VW-1:0]       best_idx_q, best_idx_d;
  logic [VW-1:0]       voice_q, voice_d;
  logic [SERIAL_W-1:0] best_q, best_d;
  logic [MASK_W-1:0]   mask_q, mask_d;
  logic [CHANNELS-1:0] idle_vec;
  logic [VW-1:0]       last_start;
  logic                hint_ok;
  logic                older;

  // Voices beyond the four with an idle bit always count as busy.
  for (genvar i = 0; i < CHANNELS; i++) begin : g_idle
    if (i < HW_VOICES) begin : g_hw
      assign idle_vec[i] = mask_q[i];
    end else begin : g_none
      assign idle_vec[i] = 1'b0;
    end
  end

  assign last_start = music_i ? VW'(1) : VW'(CHANNELS - 1);
  assign hint_ok    = !hint_i[HINT_W-1]
                    && ({1'b0, hint_i[HINT_W-2:0]} <= HINT_W'(last_start))
                    && (hint_i[HINT_W-2:2] == '0)
                    && mask_i[hint_i[1:0]];
  assign older      = serial_q[cursor_q] < best_q;
  assign counter_d  = counter_q + SERIAL_W'(1);

  always_comb begin
    busy_d     = busy_q;
    cursor_d   = cursor_q;
    last_d     = last_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    voice_d    = voice_q;
    mask_d     = mask_q;
    if (start_i) begin
      mask_d     = mask_i;
      last_d     = last_start;
      cursor_d   = '0;
      best_d     = '1;
      best_idx_d = '0;
      if (hint_ok) begin
        voice_d = VW'(hint_i[HINT_W-2:0]);
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (idle_vec[cursor_q]) begin
        voice_d = cursor_q;
        busy_d  = 1'b0;
      end else begin
        if (older) begin
          best_d     = serial_q[cursor_q];
          best_idx_d = cursor_q;
        end
        if (cursor_q == last_q) begin
          voice_d = older ? cursor_q : best_idx_q;
          busy_d  = 1'b0;
        end else begin
          cursor_d = cursor_q + VW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      counter_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        serial_q[i] <= '0;
      end
    end else begin
      busy_q <= busy_d;
      if (commit_i) begin
        counter_q         <= counter_d;
        serial_q[voice_q] <= counter_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cursor_q   <= cursor_d;
    last_q     <= last_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    voice_q    <= voice_d;
    mask_q     <= mask_d;
  end

  assign busy_o  = busy_q;
  assign voice_o = voice_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the voice channel allocator: a directed table, then random
// requests under several register settings, checked against the table or a local predictor.
// Depends on vca_pkg and voice_channel_allocator.
module testbench;
  import vca_pkg::*;

  // The block is built with its default sizes; the predictor below assumes the same.
  localparam int unsigned CHANNELS     = 4;
  localparam int unsigned STAGE_BYTES  = 32768;
  // Quiet time after draining, to cover one request still in flight in the block.
  localparam int unsigned QUIET_CYCLES = 40;
  localparam int unsigned DRAIN_LIMIT  = 20000;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 255;
  // Watchdog limit in nanoseconds for the whole run.
  localparam longint unsigned TIMEOUT_NS = 64'd10_000_000;

  typedef enum logic [1:0] {
    ROW_ASK,
    ROW_ASK_TYPED,
    ROW_SET
  } row_kind_e;

  // Receiver behaviour: streaming, coin toss, mostly stalled, or held off entirely.
  typedef enum logic [1:0] {
    RX_STREAM,
    RX_COIN,
    RX_SPARSE,
    RX_HOLD
  } rx_mode_e;

  typedef struct packed {
    row_kind_e        kind;
    cfg_reg_e         reg_idx;
    logic [CFG_W-1:0] value;
    req_t             request;
    res_t             result;
  } row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [2:0]       cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_ready_o;
  req_t             in_data_i;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  res_t             out_data_o;

  voice_channel_allocator #(
    .CHANNELS   (CHANNELS),
    .STAGE_BYTES(STAGE_BYTES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Predictor copy of the registers and of the start serials.
  logic [VOL_W-1:0]    master_level;
  logic [VOL_W-1:0]    voice_level [HW_VOICES];
  logic [RATE_W-1:0]   rate_hz;
  logic [CLOCK_W-1:0]  clock_hz;
  logic [SERIAL_W-1:0] start_stamp [CHANNELS];
  logic [SERIAL_W-1:0] stamp_count;

  // Results still owed by the block, oldest first.
  res_t awaited_results [$];
  row_t plan [$];

  int unsigned fail_count;
  int unsigned request_count;
  int unsigned reject_count;
  int unsigned cut_count;
  int unsigned steal_count;
  int unsigned write_count;
  int unsigned burst_left;

  rx_mode_e    rx_mode;
  int unsigned rx_span;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Works out the result of one request and moves the start serials on, exactly as the
  // block should. A request whose clamped length is under two bytes leaves no trace.
  function automatic res_t allot_voice(input req_t r);
    res_t                res;
    int                  hint;
    int                  last;
    int                  hw;
    int                  v;
    bit                  found;
    bit                  cut;
    int unsigned         span;
    int unsigned         vol;
    int unsigned         rate;
    int unsigned         period;
    logic [SERIAL_W-1:0] oldest_at;
    res   = '0;
    hint  = int'(r.requested_channel);
    span  = r.sound_length;
    cut   = 1'b0;
    found = 1'b0;
    if (span > STAGE_BYTES) begin
      span = STAGE_BYTES;
      cut  = 1'b1;
      cut_count++;
    end
    if (span < 2) begin
      reject_count++;
      return res;
    end
    span[0] = 1'b0;
    last = r.music_on ? 1 : CHANNELS - 1;
    if (hint >= 0 && hint <= last && r.idle_mask[hint]) begin
      hw = hint;
    end else begin
      // First idle voice wins; failing that, the oldest start, lowest index on a tie.
      // The search bound starts at all ones, so a voice stamped all ones is never older.
      hw        = 0;
      oldest_at = '1;
      for (v = 0; v <= last && !found; v++) begin
        if (r.idle_mask[v]) begin
          hw    = v;
          found = 1'b1;
        end else if (start_stamp[v] < oldest_at) begin
          oldest_at = start_stamp[v];
          hw        = v;
        end
      end
      if (!found) steal_count++;
    end
    vol = (int'(voice_level[hw]) * int'(master_level)) / FULL_MIX;
    vol = (vol * MAX_HW_VOL) / FULL_MIX;
    if (vol > MAX_HW_VOL) vol = MAX_HW_VOL;
    // A rate of zero is taken as one, so the period is then the whole clock.
    rate   = (rate_hz == '0) ? 1 : int'(rate_hz);
    period = int'(clock_hz) / rate;
    if (period < MIN_PERIOD) period = MIN_PERIOD;
    stamp_count     = stamp_count + 1'b1;
    start_stamp[hw] = stamp_count;
    res.accepted    = 1'b1;
    res.hw_channel  = hw[1:0];
    res.out_volume  = vol[OVOL_W-1:0];
    res.out_period  = period[CLOCK_W-1:0];
    res.play_length = span[PLAY_W-1:0];
    res.was_cut     = cut;
    return res;
  endfunction

  function automatic row_t ask(input int hint, input int mask, input bit music, input int len);
    row_t row;
    row = '0;
    row.kind                      = ROW_ASK;
    row.request.requested_channel = hint[HINT_W-1:0];
    row.request.idle_mask         = mask[MASK_W-1:0];
    row.request.music_on          = music;
    row.request.sound_length      = len[LEN_W-1:0];
    return row;
  endfunction

  function automatic row_t ask_typed(input int hint, input int mask, input bit music,
                                     input int len, input res_t want);
    row_t row;
    row        = ask(hint, mask, music, len);
    row.kind   = ROW_ASK_TYPED;
    row.result = want;
    return row;
  endfunction

  function automatic row_t set_reg(input cfg_reg_e idx, input int value);
    row_t row;
    row         = '0;
    row.kind    = ROW_SET;
    row.reg_idx = idx;
    row.value   = value[CFG_W-1:0];
    return row;
  endfunction

  function automatic res_t outcome(input bit acc, input int hw, input int vol, input int per,
                                   input int len, input bit cut);
    res_t res;
    res.accepted    = acc;
    res.hw_channel  = hw[1:0];
    res.out_volume  = vol[OVOL_W-1:0];
    res.out_period  = per[CLOCK_W-1:0];
    res.play_length = len[PLAY_W-1:0];
    res.was_cut     = cut;
    return res;
  endfunction

  // Random settings lean on the extremes: silence, full and over-range volumes, the
  // zero and top rates, and clocks small enough to hit the minimum period.
  function automatic logic [CFG_W-1:0] pick_setting(input cfg_reg_e idx);
    int unsigned roll;
    roll = $urandom_range(0, 5);
    if (idx == REG_SAMPLE_RATE) begin
      if (roll == 0) return '0;
      if (roll == 1) return CFG_W'(1);
      if (roll == 2) return CFG_W'(28000);
      if (roll == 3) return CFG_W'(32767);
      return CFG_W'($urandom_range(1, 28000));
    end
    if (idx == REG_AUDIO_CLOCK) begin
      if (roll == 0) return CFG_W'(1);
      if (roll == 1) return CFG_W'(4194303);
      if (roll == 2) return CFG_W'($urandom_range(1, 4096));
      return CFG_W'($urandom_range(1, 4194303));
    end
    if (roll == 0) return '0;
    if (roll == 1) return CFG_W'(128);
    if (roll == 2) return CFG_W'($urandom_range(129, 255));
    return CFG_W'($urandom_range(0, 128));
  endfunction

  // Hints mostly land on the usable voices, masks are often all busy so that voices get
  // stolen, and lengths cluster around the rejection and staging limits.
  function automatic req_t random_request();
    req_t        r;
    int          hint;
    int unsigned roll;
    if ($urandom_range(0, 3) == 0) hint = int'($urandom_range(0, 31));
    else hint = int'($urandom_range(0, 4)) - 1;
    r.requested_channel = hint[HINT_W-1:0];
    if ($urandom_range(0, 3) == 0) r.idle_mask = '0;
    else r.idle_mask = MASK_W'($urandom_range(0, 15));
    r.music_on = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 4);
    case (roll)
      0:       r.sound_length = LEN_W'($urandom_range(0, 3));
      1:       r.sound_length = LEN_W'($urandom_range(32760, 32780));
      2:       r.sound_length = LEN_W'($urandom());
      default: r.sound_length = LEN_W'($urandom_range(2, STAGE_BYTES));
    endcase
    return r;
  endfunction

  // Register writes only happen with the block idle. The valid is dropped for a cycle
  // after each transfer so that it is never lowered and raised in the same time step.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MASTER_VOL:  master_level   = value[VOL_W-1:0];
      REG_CHAN_VOL_0:  voice_level[0] = value[VOL_W-1:0];
      REG_CHAN_VOL_1:  voice_level[1] = value[VOL_W-1:0];
      REG_CHAN_VOL_2:  voice_level[2] = value[VOL_W-1:0];
      REG_CHAN_VOL_3:  voice_level[3] = value[VOL_W-1:0];
      REG_SAMPLE_RATE: rate_hz        = value[RATE_W-1:0];
      REG_AUDIO_CLOCK: clock_hz       = value[CLOCK_W-1:0];
      default: ;
    endcase
    write_count++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends one request. The sender works in bursts: at the start of each burst it may
  // sit idle for a random gap. Within a burst the valid stays high from one transfer to
  // the next, so a fresh item simply replaces the payload at the accepting edge.
  task automatic send_request(input req_t r, input bit typed, input res_t typed_res);
    int unsigned gap;
    res_t        predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    // The predictor always runs so that the start serials stay in step, but a row with
    // a result typed into the table is checked against that result instead.
    predicted = allot_voice(r);
    awaited_results.push_back(typed ? typed_res : predicted);
    request_count++;
  endtask

  // Stops sending and waits until every result owed has arrived or the drain limit
  // runs out, then lets the block settle for as long as one request could be in flight.
  task automatic settle();
    int unsigned n;
    in_valid_i <= 1'b0;
    burst_left = 0;
    n = 0;
    while (awaited_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // The receiver changes its behaviour every so often. Ready is updated at the edge,
  // so the value seen here is the one the block saw at the same edge.
  always @(posedge clk_i) begin : receiver_stall
    if (rx_span == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_span = (rx_mode == RX_HOLD) ? $urandom_range(1, 30) : $urandom_range(16, 200);
    end
    rx_span--;
    case (rx_mode)
      RX_STREAM: out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= 1'b0;
    endcase
  end

  // Each result transfer is matched with the oldest expectation, field by field.
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result transfer with nothing outstanding, got %h", $time, out_data_o);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("accepted", want.accepted, out_data_o.accepted);
        check_field("hw_channel", want.hw_channel, out_data_o.hw_channel);
        check_field("out_volume", want.out_volume, out_data_o.out_volume);
        check_field("out_period", want.out_period, out_data_o.out_period);
        check_field("play_length", want.play_length, out_data_o.play_length);
        check_field("was_cut", want.was_cut, out_data_o.was_cut);
      end
    end
  end

  initial begin : stimulus
    cfg_reg_e idx;
    bit       settled;
    int       i;
    int       phase;
    int       n;

    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    rx_span     = 0;
    rx_mode     = RX_STREAM;
    burst_left  = 0;
    fail_count  = 0;
    request_count = 0;
    reject_count  = 0;
    cut_count     = 0;
    steal_count   = 0;
    write_count   = 0;

    // Predictor state after reset: full volumes, default rate and clock, serials clear.
    master_level = FULL_MIX;
    foreach (voice_level[k]) voice_level[k] = FULL_MIX;
    rate_hz  = RATE_RESET;
    clock_hz = CLOCK_RESET;
    foreach (start_stamp[k]) start_stamp[k] = '0;
    stamp_count = '0;

    // Directed table. With the reset settings every accepted sound gets volume 64 and
    // period 160; a rejected request comes back with every field zero.
    plan.push_back(ask_typed(-1, 'hF, 0, 0, '0));                         // empty sound
    plan.push_back(ask_typed(0, 'hF, 1, 1, '0));                          // one byte
    plan.push_back(ask_typed(-1, 'hF, 0, 'hFFFFFF,
                             outcome(1, 0, 64, 160, STAGE_BYTES, 1)));    // longest, cut
    plan.push_back(ask_typed(3, 'h8, 0, STAGE_BYTES,
                             outcome(1, 3, 64, 160, STAGE_BYTES, 0)));    // hint kept
    plan.push_back(ask_typed(2, 'h0, 0, 3,
                             outcome(1, 1, 64, 160, 2, 0)));              // oldest stolen
    plan.push_back(ask(15, 'h4, 1, 100));        // hint beyond any voice, music running
    plan.push_back(ask(2, 'h4, 1, 32769));       // hint outside the music range
    plan.push_back(ask(-16, 'h2, 0, 2));         // most negative hint
    plan.push_back(ask(1, 'hF, 1, 'hFFFFFF));
    plan.push_back(ask(-1, 'h0, 1, 4097));       // steal among the two effect voices
    plan.push_back(ask(7, 'h0, 0, 5000));        // steal across all four voices
    plan.push_back(set_reg(REG_MASTER_VOL, 0));
    plan.push_back(ask_typed(-1, 'hF, 0, 10, outcome(1, 0, 0, 160, 10, 0)));
    plan.push_back(set_reg(REG_MASTER_VOL, 255));
    plan.push_back(set_reg(REG_CHAN_VOL_0, 255));                         // over range
    plan.push_back(ask_typed(0, 'h1, 0, 64, outcome(1, 0, 64, 160, 64, 0)));
    plan.push_back(set_reg(REG_CHAN_VOL_1, 0));
    plan.push_back(set_reg(REG_CHAN_VOL_2, 200));
    plan.push_back(set_reg(REG_CHAN_VOL_3, 128));
    plan.push_back(ask(1, 'h2, 0, 8));
    plan.push_back(ask(2, 'h4, 0, 8));
    plan.push_back(ask(3, 'h8, 0, 8));
    plan.push_back(set_reg(REG_SAMPLE_RATE, 0));                          // taken as one
    plan.push_back(set_reg(REG_AUDIO_CLOCK, 4194303));
    plan.push_back(ask_typed(0, 'h1, 0, 2, outcome(1, 0, 64, 4194303, 2, 0)));
    plan.push_back(set_reg(REG_SAMPLE_RATE, 28000));
    plan.push_back(set_reg(REG_AUDIO_CLOCK, 1));                          // period floor
    plan.push_back(ask_typed(-1, 'h2, 0, 6, outcome(1, 1, 0, 124, 6, 0)));
    plan.push_back(set_reg(REG_SAMPLE_RATE, 1));
    plan.push_back(ask(-1, 'h0, 1, 32767));

    // Reset is held once, at the start of the run.
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    settled = 1'b1;
    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_SET) begin
        if (!settled) settle();
        write_reg(plan[i].reg_idx, plan[i].value);
        settled = 1'b1;
      end else begin
        send_request(plan[i].request, plan[i].kind == ROW_ASK_TYPED, plan[i].result);
        settled = 1'b0;
      end
    end

    // Random phases, each under a fresh setting of every register. Now and then the
    // sender also holds back mid-phase until the block has returned everything.
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      idx = idx.first();
      do begin
        write_reg(idx, pick_setting(idx));
        idx = idx.next();
      end while (idx != idx.first());
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 199) == 0) settle();
        send_request(random_request(), 1'b0, '0);
      end
    end

    settle();
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
      fail_count++;
    end
    $display("Run covered %0d requests: %0d rejected as too short, %0d cut to the stage size,",
             request_count, reject_count, cut_count);
    $display("%0d busy voices stolen, %0d register writes; %0d failures.",
             steal_count, write_count, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hang guard: no legal run comes anywhere near this.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
